### rtl/ussd_pkg.sv
// Shared types, constants and helper functions of the ultrasonic ranger.
`default_nettype none
package ussd_pkg;

  localparam int ECHO_COUNT_BITS = 20;
  localparam int DIGITS          = 3;
  localparam int QUO_W           = ECHO_COUNT_BITS + 1;
  localparam int DIFF_W          = ECHO_COUNT_BITS + 2;
  localparam int DIV_CNT_W       = $clog2(QUO_W);
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 3;
  localparam int TICK_W          = 16;
  localparam int TRIG_W          = 10;
  localparam int DIVISOR_W       = 10;
  localparam int REFRESH_W       = 8;
  localparam int DIST_W          = 11;
  localparam int EN_W            = 3;
  localparam int SEG_W           = 7;
  localparam int POS_W           = 2;
  localparam int BCD_W           = 4;
  localparam int SPLIT_W         = 10;

  localparam int SHOW_LIMIT   = 1000;
  localparam int DIST_POS_MAX = 1023;
  localparam int DIST_NEG_MAG = 1024;
  localparam int HUNDRED      = 100;
  localparam int TEN          = 10;

  localparam logic signed [DIST_W-1:0] DIST_HUNDRED = 11'sd100;
  localparam logic signed [DIST_W-1:0] DIST_TEN     = 11'sd10;

  localparam logic [TRIG_W-1:0]     TRIGGER_TICKS_RST    = 10'd10;
  localparam logic [TICK_W-1:0]     CORRECTION_TICKS_RST = 16'd0;
  localparam logic [DIVISOR_W-1:0]  DIVISOR_RST          = 10'd53;
  localparam logic [TICK_W-1:0]     DIGIT_TICKS_RST      = 16'd2000;
  localparam logic [TICK_W-1:0]     HOLD_TICKS_RST       = 16'd10000;
  localparam logic [TICK_W-1:0]     BLANK_TICKS_RST      = 16'd11000;
  localparam logic [REFRESH_W-1:0]  REFRESH_COUNT_RST    = 8'd15;

  localparam logic [EN_W-1:0] EN_OFF      = 3'd0;
  localparam logic [EN_W-1:0] EN_HUNDREDS = 3'd3;
  localparam logic [EN_W-1:0] EN_TENS     = 3'd5;
  localparam logic [EN_W-1:0] EN_ONES     = 3'd6;

  typedef enum logic [2:0] {
    PH_TRIGGER, PH_WAIT, PH_COUNT, PH_DIGIT, PH_HOLD, PH_BLANK
  } phase_t;

  typedef enum logic [1:0] {ST_START, ST_HOLD, ST_BLANK, ST_END} stage_t;

  typedef enum logic [2:0] {
    CTL_IDLE, CTL_DIV, CTL_RESULT, CTL_SPLIT, CTL_FINISH
  } ctl_state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRIGGER_TICKS, CFG_CORRECTION_TICKS, CFG_DIVISOR, CFG_DIGIT_TICKS,
    CFG_HOLD_TICKS, CFG_BLANK_TICKS, CFG_REFRESH_COUNT
  } cfg_reg_t;

  typedef struct packed {
    logic tick;
    logic div_start;
    logic div_step;
    logic result;
    logic split_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic measure;
    logic div_last;
    logic res_shown;
    logic split_done;
  } dp_sts_t;

  typedef struct packed {
    phase_t                phase;
    logic [REFRESH_W-1:0]  refresh_left;
    logic [POS_W-1:0]      position;
  } enter_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] v);
    logic [SEG_W-1:0] s;
    unique case (v)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [EN_W-1:0] enable_of(input logic [POS_W-1:0] p);
    logic [EN_W-1:0] e;
    unique case (p)
      2'd0:    e = EN_HUNDREDS;
      2'd1:    e = EN_TENS;
      default: e = EN_ONES;
    endcase
    return e;
  endfunction

  function automatic logic [POS_W-1:0] digit_pos(input logic signed [DIST_W-1:0] d);
    logic [POS_W-1:0] p;
    priority if (d >= DIST_HUNDRED) p = 2'd0;
    else if (d >= DIST_TEN)         p = 2'd1;
    else                            p = 2'd2;
    return p;
  endfunction

  // Resolve the display sequence from a given stage, skipping empty parts.
  function automatic enter_t enter_display(
    input stage_t                    stage,
    input logic                      shown,
    input logic signed [DIST_W-1:0]  distance,
    input logic                      hold_nz,
    input logic                      blank_nz,
    input logic [REFRESH_W-1:0]      rl
  );
    enter_t                e;
    logic [REFRESH_W-1:0]  rl_dec;
    rl_dec         = rl - REFRESH_W'(1);
    e.phase        = PH_TRIGGER;
    e.refresh_left = rl;
    e.position     = digit_pos(distance);
    priority if (stage == ST_START && shown) begin
      e.phase = PH_DIGIT;
    end else if ((stage == ST_START || stage == ST_HOLD) && hold_nz) begin
      e.phase = PH_HOLD;
    end else if (stage != ST_END && blank_nz) begin
      e.phase = PH_BLANK;
    end else begin
      e.refresh_left = rl_dec;
      priority if (rl_dec == '0) begin
        e.phase = PH_TRIGGER;
      end else if (shown) begin
        e.phase = PH_DIGIT;
      end else if (hold_nz) begin
        e.phase = PH_HOLD;
      end else if (blank_nz) begin
        e.phase = PH_BLANK;
      end else begin
        e.phase        = PH_TRIGGER;
        e.refresh_left = '0;
      end
    end
    return e;
  endfunction

endpackage
`default_nettype wire

### rtl/ussd_in_if.sv
// Input channel: one tick carrying the sampled echo level.
`default_nettype none
interface ussd_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface
`default_nettype wire

### rtl/ussd_out_if.sv
// Result channel: trigger, display drive and distance status per tick.
`default_nettype none
interface ussd_out_if;
  import ussd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      trigger_out;
  logic [EN_W-1:0]           digit_enables;
  logic [SEG_W-1:0]          segments;
  logic signed [DIST_W-1:0]  distance_cm;
  logic                      distance_shown;
  logic                      measure_done;

  modport source (output valid, output trigger_out, output digit_enables, output segments,
                  output distance_cm, output distance_shown, output measure_done,
                  input ready);
  modport sink   (input valid, input trigger_out, input digit_enables, input segments,
                  input distance_cm, input distance_shown, input measure_done,
                  output ready);
endinterface
`default_nettype wire

### rtl/ussd_ctrl.sv
// Controller: handshake and sequencing of tick, divide, digit split and finish.
`default_nettype none
module ussd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire ussd_pkg::dp_sts_t sts,
  output      ussd_pkg::ctl_cmd_t cmd
);
  import ussd_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == CTL_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_IDLE:   if (accept && sts.measure) state_nxt = CTL_DIV;
      CTL_DIV:    if (sts.div_last) state_nxt = CTL_RESULT;
      CTL_RESULT: state_nxt = sts.res_shown ? CTL_SPLIT : CTL_FINISH;
      CTL_SPLIT:  if (sts.split_done) state_nxt = CTL_FINISH;
      CTL_FINISH: state_nxt = CTL_IDLE;
      default:    state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.tick       = (state_r == CTL_IDLE) && accept && !sts.measure;
    cmd.div_start  = (state_r == CTL_IDLE) && accept && sts.measure;
    cmd.div_step   = (state_r == CTL_DIV);
    cmd.result     = (state_r == CTL_RESULT);
    cmd.split_step = (state_r == CTL_SPLIT);
    cmd.finish     = (state_r == CTL_FINISH);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.tick || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_measure_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.measure) |=> (state_r == CTL_DIV))
    else $error("measurement tick did not start the divider");

  a_busy_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != CTL_IDLE) |-> !out_valid_r)
    else $error("result pending while a measurement is in progress");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == CTL_FINISH) || $past(accept && !sts.measure))
    else $error("result appeared without a tick or a finished measurement");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CTL_FINISH) |=> (state_r == CTL_IDLE) && out_valid_r)
    else $error("finished measurement did not produce a result");
`endif
endmodule
`default_nettype wire

### rtl/ussd_dp.sv
// Datapath: configuration, ranging phases, serial divider, digit split, result register.
`default_nettype none
module ussd_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [ussd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ussd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 echo_level,
  input  wire ussd_pkg::ctl_cmd_t                   cmd,
  output      ussd_pkg::dp_sts_t                    sts,
  output      logic                                 trigger_out,
  output      logic [ussd_pkg::EN_W-1:0]            digit_enables,
  output      logic [ussd_pkg::SEG_W-1:0]           segments,
  output      logic signed [ussd_pkg::DIST_W-1:0]   distance_cm,
  output      logic                                 distance_shown,
  output      logic                                 measure_done
);
  import ussd_pkg::*;

  // configuration
  logic [TRIG_W-1:0]    trig_r;
  logic [TICK_W-1:0]    corr_r;
  logic [DIVISOR_W-1:0] dvsr_r;
  logic [TICK_W-1:0]    digit_r;
  logic [TICK_W-1:0]    hold_r;
  logic [TICK_W-1:0]    blank_r;
  logic [REFRESH_W-1:0] refresh_r;

  logic [TRIG_W-1:0]    trig_eff;
  logic [DIVISOR_W-1:0] dvsr_eff;
  logic [TICK_W-1:0]    digit_eff;
  logic [REFRESH_W-1:0] refresh_eff;
  logic                 hold_nz, blank_nz;

  // ranging state
  phase_t                     phase_r, phase_nxt;
  logic [TICK_W-1:0]          pt_r, pt_nxt;
  logic [ECHO_COUNT_BITS-1:0] ec_r, ec_nxt;
  logic signed [DIST_W-1:0]   last_dist_r, last_dist_nxt;
  logic [BCD_W-1:0]           dval_r [DIGITS];
  logic [BCD_W-1:0]           dval_nxt [DIGITS];
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [REFRESH_W-1:0]       rl_r, rl_nxt;
  logic                       shown_r, shown_nxt;

  // divider and split
  logic [QUO_W-1:0]           q_r, q_nxt;
  logic [DIVISOR_W-1:0]       rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]       dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag_full;
  logic [DIVISOR_W:0]         rem_sh, rem_sub;
  logic                       rem_ge;
  logic [DIST_W-1:0]          mag_sat;
  logic signed [DIST_W-1:0]   dist_calc;
  logic                       shown_calc;
  logic                       res_shown_r, res_shown_nxt;
  logic signed [DIST_W-1:0]   res_dist_r, res_dist_nxt;
  logic [SPLIT_W-1:0]         val_r, val_nxt;
  logic [BCD_W-1:0]           hund_r, hund_nxt;
  logic [BCD_W-1:0]           tens_r, tens_nxt;

  // display sequencing
  logic [TICK_W:0]            pt_inc;
  logic [POS_W-1:0]           pos_c;
  stage_t                     stage_sel;
  enter_t                     ent;

  // result register
  logic                       o_trig_r, o_trig_nxt;
  logic [EN_W-1:0]            o_en_r, o_en_nxt;
  logic [SEG_W-1:0]           o_seg_r, o_seg_nxt;
  logic signed [DIST_W-1:0]   o_dist_r, o_dist_nxt;
  logic                       o_shown_r, o_shown_nxt;
  logic                       o_done_r, o_done_nxt;

  assign trig_eff    = (trig_r == '0) ? TRIG_W'(1) : trig_r;
  assign dvsr_eff    = (dvsr_r == '0) ? DIVISOR_W'(1) : dvsr_r;
  assign digit_eff   = (digit_r == '0) ? TICK_W'(1) : digit_r;
  assign refresh_eff = (refresh_r == '0) ? REFRESH_W'(1) : refresh_r;
  assign hold_nz     = (hold_r != '0);
  assign blank_nz    = (blank_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r    <= TRIGGER_TICKS_RST;
      corr_r    <= CORRECTION_TICKS_RST;
      dvsr_r    <= DIVISOR_RST;
      digit_r   <= DIGIT_TICKS_RST;
      hold_r    <= HOLD_TICKS_RST;
      blank_r   <= BLANK_TICKS_RST;
      refresh_r <= REFRESH_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TRIGGER_TICKS:    trig_r    <= cfg_data[TRIG_W-1:0];
        CFG_CORRECTION_TICKS: corr_r    <= cfg_data[TICK_W-1:0];
        CFG_DIVISOR:          dvsr_r    <= cfg_data[DIVISOR_W-1:0];
        CFG_DIGIT_TICKS:      digit_r   <= cfg_data[TICK_W-1:0];
        CFG_HOLD_TICKS:       hold_r    <= cfg_data[TICK_W-1:0];
        CFG_BLANK_TICKS:      blank_r   <= cfg_data[TICK_W-1:0];
        CFG_REFRESH_COUNT:    refresh_r <= cfg_data[REFRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // divider arithmetic
  assign diff     = $signed({2'b00, ec_r}) -
                    $signed({{(DIFF_W-TICK_W){1'b0}}, corr_r});
  assign mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign rem_sh   = {rem_r, q_r[QUO_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    if (neg_r) begin
      mag_sat    = (q_r > QUO_W'(DIST_NEG_MAG)) ? DIST_W'(DIST_NEG_MAG) : q_r[DIST_W-1:0];
      shown_calc = (q_r == '0);
    end else begin
      mag_sat    = (q_r > QUO_W'(DIST_POS_MAX)) ? DIST_W'(DIST_POS_MAX) : q_r[DIST_W-1:0];
      shown_calc = (q_r < QUO_W'(SHOW_LIMIT));
    end
    dist_calc = neg_r ? $signed(-mag_sat) : $signed(mag_sat);
  end

  assign sts.measure    = (phase_r == PH_COUNT) && !echo_level;
  assign sts.div_last   = (cnt_r == DIV_CNT_W'(QUO_W-1));
  assign sts.res_shown  = shown_calc;
  assign sts.split_done = (val_r < SPLIT_W'(TEN));

  assign pt_inc = {1'b0, pt_r} + (TICK_W+1)'(1);
  assign pos_c  = (pos_r >= POS_W'(DIGITS)) ? POS_W'(DIGITS-1) : pos_r;

  always_comb begin
    unique case (phase_r)
      PH_DIGIT: stage_sel = ST_HOLD;
      PH_HOLD:  stage_sel = ST_BLANK;
      default:  stage_sel = ST_END;
    endcase
    if (cmd.finish) begin
      ent = enter_display(ST_START, res_shown_r, res_dist_r, hold_nz, blank_nz, refresh_eff);
    end else begin
      ent = enter_display(stage_sel, shown_r, last_dist_r, hold_nz, blank_nz, rl_r);
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    pt_nxt        = pt_r;
    ec_nxt        = ec_r;
    last_dist_nxt = last_dist_r;
    dval_nxt      = dval_r;
    pos_nxt       = pos_r;
    rl_nxt        = rl_r;
    shown_nxt     = shown_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    res_shown_nxt = res_shown_r;
    res_dist_nxt  = res_dist_r;
    val_nxt       = val_r;
    hund_nxt      = hund_r;
    tens_nxt      = tens_r;
    o_trig_nxt    = o_trig_r;
    o_en_nxt      = o_en_r;
    o_seg_nxt     = o_seg_r;
    o_dist_nxt    = o_dist_r;
    o_shown_nxt   = o_shown_r;
    o_done_nxt    = o_done_r;

    if (cmd.tick) begin
      o_trig_nxt  = 1'b0;
      o_en_nxt    = EN_OFF;
      o_seg_nxt   = '0;
      o_dist_nxt  = last_dist_r;
      o_shown_nxt = shown_r;
      o_done_nxt  = 1'b0;
      unique case (phase_r)
        PH_TRIGGER: begin
          o_trig_nxt = 1'b1;
          if (pt_inc >= (TICK_W+1)'(trig_eff)) begin
            phase_nxt = PH_WAIT;
            pt_nxt    = '0;
            ec_nxt    = '0;
          end else begin
            pt_nxt = pt_inc[TICK_W-1:0];
          end
        end
        PH_WAIT: begin
          if (echo_level) begin
            ec_nxt    = ECHO_COUNT_BITS'(1);
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (echo_level && (ec_r != '1)) ec_nxt = ec_r + ECHO_COUNT_BITS'(1);
        end
        PH_DIGIT: begin
          o_en_nxt  = enable_of(pos_c);
          o_seg_nxt = seg_of(dval_r[pos_c]);
          if (pt_inc >= {1'b0, digit_eff}) begin
            if (pos_r < POS_W'(DIGITS-1)) begin
              pos_nxt = pos_r + POS_W'(1);
              pt_nxt  = '0;
            end else begin
              phase_nxt = ent.phase;
              rl_nxt    = ent.refresh_left;
              pos_nxt   = ent.position;
              pt_nxt    = '0;
            end
          end else begin
            pt_nxt = pt_inc[TICK_W-1:0];
          end
        end
        PH_HOLD, PH_BLANK: begin
          if (phase_r == PH_HOLD && shown_r) begin
            o_en_nxt  = enable_of(POS_W'(DIGITS-1));
            o_seg_nxt = seg_of(dval_r[DIGITS-1]);
          end
          if (pt_inc >= {1'b0, (phase_r == PH_HOLD) ? hold_r : blank_r}) begin
            phase_nxt = ent.phase;
            rl_nxt    = ent.refresh_left;
            pos_nxt   = ent.position;
            pt_nxt    = '0;
          end else begin
            pt_nxt = pt_inc[TICK_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_TRIGGER;
          pt_nxt    = '0;
        end
      endcase
    end

    if (cmd.div_start) begin
      neg_nxt = diff[DIFF_W-1];
      q_nxt   = mag_full[QUO_W-1:0];
      rem_nxt = '0;
      dvs_nxt = dvsr_eff;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = rem_ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      q_nxt   = {q_r[QUO_W-2:0], rem_ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.result) begin
      res_shown_nxt = shown_calc;
      res_dist_nxt  = dist_calc;
      val_nxt       = q_r[SPLIT_W-1:0];
      hund_nxt      = '0;
      tens_nxt      = '0;
    end

    if (cmd.split_step) begin
      priority if (val_r >= SPLIT_W'(HUNDRED)) begin
        val_nxt  = val_r - SPLIT_W'(HUNDRED);
        hund_nxt = hund_r + BCD_W'(1);
      end else if (val_r >= SPLIT_W'(TEN)) begin
        val_nxt  = val_r - SPLIT_W'(TEN);
        tens_nxt = tens_r + BCD_W'(1);
      end else begin
        val_nxt = val_r;
      end
    end

    if (cmd.finish) begin
      shown_nxt     = res_shown_r;
      last_dist_nxt = res_dist_r;
      if (res_shown_r) begin
        dval_nxt[0] = hund_r;
        dval_nxt[1] = tens_r;
        dval_nxt[2] = val_r[BCD_W-1:0];
      end
      phase_nxt   = ent.phase;
      rl_nxt      = ent.refresh_left;
      pos_nxt     = ent.position;
      pt_nxt      = '0;
      o_trig_nxt  = 1'b0;
      o_en_nxt    = EN_OFF;
      o_seg_nxt   = '0;
      o_dist_nxt  = res_dist_r;
      o_shown_nxt = res_shown_r;
      o_done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRIGGER;
      pt_r        <= '0;
      ec_r        <= '0;
      last_dist_r <= '0;
      for (int i = 0; i < DIGITS; i++) dval_r[i] <= '0;
      pos_r       <= '0;
      rl_r        <= '0;
      shown_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pt_r        <= pt_nxt;
      ec_r        <= ec_nxt;
      last_dist_r <= last_dist_nxt;
      dval_r      <= dval_nxt;
      pos_r       <= pos_nxt;
      rl_r        <= rl_nxt;
      shown_r     <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    res_shown_r <= res_shown_nxt;
    res_dist_r  <= res_dist_nxt;
    val_r       <= val_nxt;
    hund_r      <= hund_nxt;
    tens_r      <= tens_nxt;
    o_trig_r    <= o_trig_nxt;
    o_en_r      <= o_en_nxt;
    o_seg_r     <= o_seg_nxt;
    o_dist_r    <= o_dist_nxt;
    o_shown_r   <= o_shown_nxt;
    o_done_r    <= o_done_nxt;
  end

  assign trigger_out    = o_trig_r;
  assign digit_enables  = o_en_r;
  assign segments       = o_seg_r;
  assign distance_cm    = o_dist_r;
  assign distance_shown = o_shown_r;
  assign measure_done   = o_done_r;

`ifndef SYNTHESIS
  a_shown_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r |-> (!last_dist_r[DIST_W-1] && (last_dist_r < $signed(DIST_W'(SHOW_LIMIT)))))
    else $error("shown distance outside the displayable range");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r |-> (dval_r[0] < BCD_W'(TEN)) && (dval_r[1] < BCD_W'(TEN)) &&
                (dval_r[2] < BCD_W'(TEN)))
    else $error("stored display digit is not decimal");

  a_digit_phase_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIGIT) |-> shown_r)
    else $error("digit phase entered without a shown distance");
`endif
endmodule
`default_nettype wire

### rtl/ultrasonic_ranger_seven_segment.sv
// Ultrasonic ranger with three-digit multiplexed seven-segment display, top level.
//
// Each transfer on in_ch is one microsecond tick carrying the echo level and yields
// exactly one transfer on out_ch. A new tick is taken in the cycle the previous
// result is taken. The tick on which the echo falls runs the bit-serial divider (one
// quotient bit per cycle) and, if the distance is shown, a subtract-by-100/10 digit
// split before its result appears; no tick is taken meanwhile. The configuration
// port may be written whenever no tick is in flight.
`default_nettype none
module ultrasonic_ranger_seven_segment (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ussd_in_if.sink                                in_ch,
  ussd_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ussd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ussd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ussd_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ussd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ussd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .echo_level     (in_ch.echo_level),
    .cmd            (cmd),
    .sts            (sts),
    .trigger_out    (out_ch.trigger_out),
    .digit_enables  (out_ch.digit_enables),
    .segments       (out_ch.segments),
    .distance_cm    (out_ch.distance_cm),
    .distance_shown (out_ch.distance_shown),
    .measure_done   (out_ch.measure_done)
  );
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the ranger: tick stream in, per-tick display frames checked.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ussd_pkg::*;

  typedef struct {
    logic [TRIG_W-1:0]     trig;
    logic [TICK_W-1:0]     corr;
    logic [DIVISOR_W-1:0]  div;
    logic [TICK_W-1:0]     dig;
    logic [TICK_W-1:0]     hold;
    logic [TICK_W-1:0]     blank;
    logic [REFRESH_W-1:0]  refresh;
  } ranger_cfg_t;

  typedef struct {
    phase_t                    ph;
    int unsigned               ticks;
    logic [ECHO_COUNT_BITS-1:0] echo_cnt;
    logic signed [DIST_W-1:0]  distance;
    logic [BCD_W-1:0]          dv [DIGITS];
    logic [POS_W-1:0]          pos;
    logic [REFRESH_W-1:0]      left;
    logic                      shown;
  } ranger_state_t;

  typedef struct packed {
    logic                      trigger;
    logic [EN_W-1:0]           en;
    logic [SEG_W-1:0]          seg;
    logic signed [DIST_W-1:0]  distance;
    logic                      shown;
    logic                      done;
  } ranger_frame_t;

  localparam logic [SEG_W-1:0] SEG_PATTERN [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic drv_valid = 1'b0;
  logic drv_echo = 1'b0;
  logic rdy = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ussd_in_if  in_ch ();
  ussd_out_if out_ch ();

  assign in_ch.valid      = drv_valid;
  assign in_ch.echo_level = drv_echo;
  assign out_ch.ready     = rdy;

  ultrasonic_ranger_seven_segment uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ranger_cfg_t   model_cfg;
  ranger_state_t gen_st;
  ranger_state_t chk_st;
  ranger_frame_t mon_want;
  ranger_frame_t mon_got;

  logic          echo_queue [$];
  ranger_frame_t predicted_q [$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  hold_left = 0;
  logic stall_done = 1'b0;
  logic calm;

  assign calm = (results_seen >= 700) && (results_seen < 1000);

  function automatic int unsigned floor_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic ranger_state_t ranger_reset();
    ranger_state_t s;
    s.ph       = PH_TRIGGER;
    s.ticks    = 0;
    s.echo_cnt = '0;
    s.distance = '0;
    s.dv[0]    = '0;
    s.dv[1]    = '0;
    s.dv[2]    = '0;
    s.pos      = '0;
    s.left     = '0;
    s.shown    = 1'b0;
    return s;
  endfunction

  function automatic void enter_refresh(inout ranger_state_t s, input ranger_cfg_t c,
                                        input stage_t from);
    stage_t stg;
    bit     fin;
    stg = from;
    fin = 1'b0;
    s.ticks = 0;
    while (!fin) begin
      case (stg)
        ST_START: begin
          if (s.shown) begin
            s.ph = PH_DIGIT;
            if (s.distance >= 100) s.pos = 2'd0;
            else if (s.distance >= 10) s.pos = 2'd1;
            else s.pos = 2'd2;
            fin = 1'b1;
          end else begin
            stg = ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (c.hold != 0) begin
            s.ph = PH_HOLD;
            fin = 1'b1;
          end else begin
            stg = ST_BLANK;
          end
        end
        ST_BLANK: begin
          if (c.blank != 0) begin
            s.ph = PH_BLANK;
            fin = 1'b1;
          end else begin
            stg = ST_END;
          end
        end
        default: begin
          s.left = s.left - 8'd1;
          if (s.left == 0) begin
            s.ph = PH_TRIGGER;
            fin = 1'b1;
          end else begin
            stg = ST_START;
          end
        end
      endcase
    end
  endfunction

  function automatic void light(inout ranger_frame_t f, input ranger_state_t s,
                                input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    logic [BCD_W-1:0] v;
    q = (p > 2) ? 2'd2 : p;
    v = s.dv[q];
    f.en = (q == 0) ? EN_HUNDREDS : ((q == 1) ? EN_TENS : EN_ONES);
    f.seg = (v < 10) ? SEG_PATTERN[v] : '0;
  endfunction

  function automatic ranger_frame_t ranger_tick(inout ranger_state_t s, input ranger_cfg_t c,
                                                input logic echo);
    ranger_frame_t f;
    longint diff;
    longint cw;
    longint dv;
    longint d;
    int unsigned u;
    f = '0;
    case (s.ph)
      PH_TRIGGER: begin
        f.trigger = 1'b1;
        if (s.ticks + 1 >= floor_one(c.trig)) begin
          s.ph = PH_WAIT;
          s.ticks = 0;
          s.echo_cnt = '0;
        end else begin
          s.ticks++;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          s.echo_cnt = 1;
          s.ph = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (s.echo_cnt != '1) s.echo_cnt++;
        end else begin
          diff = s.echo_cnt;
          cw = c.corr;
          diff = diff - cw;
          dv = floor_one(c.div);
          d = diff / dv;
          s.shown = (d >= 0) && (d <= 999);
          if (d > 1023) d = 1023;
          if (d < -1024) d = -1024;
          s.distance = d[DIST_W-1:0];
          if (s.shown) begin
            u = 32'(d);
            s.dv[0] = 4'(u / 100);
            s.dv[1] = 4'((u / 10) % 10);
            s.dv[2] = 4'(u % 10);
          end
          f.done = 1'b1;
          s.left = (c.refresh == 0) ? 8'd1 : c.refresh;
          enter_refresh(s, c, ST_START);
        end
      end
      PH_DIGIT: begin
        light(f, s, s.pos);
        if (s.ticks + 1 >= floor_one(c.dig)) begin
          if (s.pos < 2) begin
            s.pos++;
            s.ticks = 0;
          end else begin
            enter_refresh(s, c, ST_HOLD);
          end
        end else begin
          s.ticks++;
        end
      end
      PH_HOLD: begin
        if (s.shown) light(f, s, 2'd2);
        if (s.ticks + 1 >= c.hold) enter_refresh(s, c, ST_BLANK);
        else s.ticks++;
      end
      PH_BLANK: begin
        if (s.ticks + 1 >= c.blank) enter_refresh(s, c, ST_END);
        else s.ticks++;
      end
      default: begin
        s.ph = PH_TRIGGER;
        s.ticks = 0;
      end
    endcase
    f.distance = s.distance;
    f.shown = s.shown;
    return f;
  endfunction

  function automatic ranger_cfg_t make_cfg(input int t, input int cr, input int dv,
                                           input int dg, input int h, input int b,
                                           input int r);
    ranger_cfg_t c;
    c.trig    = t[TRIG_W-1:0];
    c.corr    = cr[TICK_W-1:0];
    c.div     = dv[DIVISOR_W-1:0];
    c.dig     = dg[TICK_W-1:0];
    c.hold    = h[TICK_W-1:0];
    c.blank   = b[TICK_W-1:0];
    c.refresh = r[REFRESH_W-1:0];
    return c;
  endfunction

  function automatic ranger_cfg_t random_cfg();
    ranger_cfg_t c;
    c.trig    = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 6));
    c.corr    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 30));
    c.div     = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
    c.dig     = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    c.hold    = 16'($urandom_range(0, 4));
    c.blank   = 16'($urandom_range(0, 4));
    c.refresh = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic start_setting(input ranger_cfg_t c);
    wait_drained();
    write_reg(CFG_TRIGGER_TICKS,    16'(c.trig));
    write_reg(CFG_CORRECTION_TICKS, c.corr);
    write_reg(CFG_DIVISOR,          16'(c.div));
    write_reg(CFG_DIGIT_TICKS,      c.dig);
    write_reg(CFG_HOLD_TICKS,       c.hold);
    write_reg(CFG_BLANK_TICKS,      c.blank);
    write_reg(CFG_REFRESH_COUNT,    16'(c.refresh));
    model_cfg = c;
  endtask

  task automatic push_tick(input logic e);
    echo_queue.push_back(e);
    void'(ranger_tick(gen_st, model_cfg, e));
    n_queued++;
  endtask

  // clean echo pulse of h ticks, started once the ranger listens
  task automatic ping(input int h);
    int gap;
    while (gen_st.ph != PH_WAIT) push_tick($urandom_range(0, 3) == 0);
    gap = $urandom_range(0, 3);
    repeat (gap) push_tick(1'b0);
    repeat (h) push_tick(1'b1);
    push_tick(1'b0);
  endtask

  task automatic garble();
    while (gen_st.ph != PH_WAIT) push_tick($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 25)) push_tick(1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_ch.ready) begin
      if (echo_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        drv_valid <= 1'b1;
        drv_echo  <= echo_queue.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rdy <= 1'b0;
    end else begin
      rdy <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 8);
      if (in_ch.valid && in_ch.ready) begin
        mon_want = ranger_tick(chk_st, model_cfg, in_ch.echo_level);
        predicted_q.push_back(mon_want);
        n_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        mon_got = {out_ch.trigger_out, out_ch.digit_enables, out_ch.segments,
                   out_ch.distance_cm, out_ch.distance_shown, out_ch.measure_done};
        if (predicted_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer %0d: trig=%0b en=%0d seg=%h dist=%0d shown=%0b done=%0b",
                     results_seen, mon_got.trigger, mon_got.en, mon_got.seg,
                     $signed(mon_got.distance), mon_got.shown, mon_got.done);
        end else begin
          mon_want = predicted_q.pop_front();
          if (mon_got !== mon_want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at transfer %0d:", results_seen);
              $display("  expected trig=%0b en=%0d seg=%h dist=%0d shown=%0b done=%0b",
                       mon_want.trigger, mon_want.en, mon_want.seg,
                       $signed(mon_want.distance), mon_want.shown, mon_want.done);
              $display("  actual   trig=%0b en=%0d seg=%h dist=%0d shown=%0b done=%0b",
                       mon_got.trigger, mon_got.en, mon_got.seg,
                       $signed(mon_got.distance), mon_got.shown, mon_got.done);
            end
          end
        end
      end
    end
  end

  // hold off the result side once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && results_seen >= 350) begin
      hold_left  <= 300;
      stall_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    int start;
    model_cfg = make_cfg(TRIGGER_TICKS_RST, CORRECTION_TICKS_RST, DIVISOR_RST,
                         DIGIT_TICKS_RST, HOLD_TICKS_RST, BLANK_TICKS_RST,
                         REFRESH_COUNT_RST);
    gen_st = ranger_reset();
    chk_st = ranger_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // digit boundaries and interior zeros
    start_setting(make_cfg(1, 0, 1, 1, 1, 1, 1));
    ping(1);
    ping(7);
    ping(10);
    ping(42);
    ping(100);
    ping(105);

    // zero lengths act as one, empty refresh, small negative truncating to zero
    start_setting(make_cfg(0, 4, 2, 0, 0, 0, 0));
    ping(3);
    ping(1);
    ping(9);
    ping(50);

    // largest correction, most refreshes
    start_setting(make_cfg(40, 65535, 0, 2, 1, 0, 255));
    ping(2);

    start_setting(make_cfg(2, 3, 1023, 30, 0, 3, 2));
    ping(3);
    ping(70);
    ping(20);

    repeat (5) begin
      start_setting(random_cfg());
      start = n_queued;
      while (n_queued - start < 110) begin
        if ($urandom_range(0, 99) < 15) garble();
        else if ($urandom_range(0, 9) == 0) ping($urandom_range(60, 150));
        else ping($urandom_range(1, 60));
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
